// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and register indexes for the swept box collision block.
// ----------------------------------------------------------------------------
package sbc_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} reg_idx_t;

	// per-axis status that travels beside the divider pipes
	typedef struct packed {
		logic zero_vel;   // displacement is zero on this axis
		logic overlap;    // strict overlap on this axis
		logic vel_neg;    // displacement is negative
	} axis_flags_t;

endpackage

// ===== src/sbc_if.sv =====
// ----------------------------------------------------------------------------
// sbc request and result channels
// Valid/ready channels carrying one box pair request and one result.
// ----------------------------------------------------------------------------
interface sbc_req_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] mover_pos_x;
	logic signed [CW-1:0] mover_pos_y;
	logic signed [CW-1:0] mover_pos_z;
	logic signed [CW-1:0] box_pos_x;
	logic signed [CW-1:0] box_pos_y;
	logic signed [CW-1:0] box_pos_z;
	logic [CW-2:0] box_size_x;
	logic [CW-2:0] box_size_y;
	logic [CW-2:0] box_size_z;
	logic signed [CW-1:0] vel_x;
	logic signed [CW-1:0] vel_y;
	logic signed [CW-1:0] vel_z;

	modport source (output valid, mover_pos_x, mover_pos_y, mover_pos_z,
		box_pos_x, box_pos_y, box_pos_z, box_size_x, box_size_y, box_size_z,
		vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, mover_pos_x, mover_pos_y, mover_pos_z,
		box_pos_x, box_pos_y, box_pos_z, box_size_x, box_size_y, box_size_z,
		vel_x, vel_y, vel_z, output ready);
endinterface

interface sbc_rsp_if #(parameter int FB = 16);
	logic valid;
	logic ready;
	logic [FB:0] hit_time;
	logic signed [1:0] normal_x;
	logic signed [1:0] normal_y;
	logic signed [1:0] normal_z;

	modport source (output valid, hit_time, normal_x, normal_y, normal_z,
		input ready);
	modport sink (input valid, hit_time, normal_x, normal_y, normal_z,
		output ready);
endinterface

// ===== src/sbc_div.sv =====
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider: floor(gap * 2^FB / den), saturated to +-2.0.
// One quotient bit per stage, one request per enabled cycle.
// ----------------------------------------------------------------------------
module sbc_div #(
	parameter int FB = 16,
	parameter int DW = 35,
	parameter int NW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [DW-1:0] gap,
	input  logic [NW-1:0]        den,
	output logic signed [FB+2:0] quo
);
	localparam logic signed [FB+2:0] TSAT = (FB+3)'(2) <<< FB;

	logic [NW-1:0] rem_s [0:FB];
	logic [FB:0]   q_s   [0:FB];
	logic [NW-1:0] den_s [0:FB];
	logic          neg_s [0:FB];
	logic          sat_s [0:FB];

	logic          neg_c;
	logic [DW-1:0] mag_c;
	logic          sat_c;
	logic          q0_c;
	logic [DW-1:0] r0_c;
	logic [NW-1:0] rem_n [1:FB];
	logic          bit_n [1:FB];
	logic [NW:0]   sh_n  [1:FB];
	logic [FB:0]   qf_c;
	logic signed [FB+2:0] qs_c;

	// first stage: sign, magnitude, saturation and integer bit
	always_comb begin
		neg_c = gap[DW-1];
		mag_c = neg_c ? DW'(-gap) : DW'(gap);
		sat_c = mag_c >= DW'({den, 1'b0});
		q0_c  = mag_c >= DW'(den);
		r0_c  = q0_c ? mag_c - DW'(den) : mag_c;
	end

	// one fraction bit per stage
	always_comb begin
		for (int i = 1; i <= FB; i++) begin
			sh_n[i]  = {rem_s[i-1], 1'b0};
			bit_n[i] = sh_n[i] >= (NW+1)'(den_s[i-1]);
			rem_n[i] = bit_n[i] ? NW'(sh_n[i] - (NW+1)'(den_s[i-1])) : NW'(sh_n[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= NW'(r0_c);
			q_s[0]   <= (FB+1)'(q0_c);
			den_s[0] <= den;
			neg_s[0] <= neg_c;
			sat_s[0] <= sat_c;
			for (int i = 1; i <= FB; i++) begin
				rem_s[i] <= rem_n[i];
				q_s[i]   <= {q_s[i-1][FB-1:0], bit_n[i]};
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				sat_s[i] <= sat_s[i-1];
			end
		end
	end

	// sign fix: round toward minus infinity
	always_comb begin
		qf_c = q_s[FB];
		qs_c = (FB+3)'(qf_c);
		if (sat_s[FB])
			qs_c = neg_s[FB] ? -TSAT : TSAT;
		else if (neg_s[FB])
			qs_c = -(qs_c + (FB+3)'(rem_s[FB] != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo <= '0;
		end else if (en) begin
			quo <= qs_c;
		end
	end
endmodule

// ===== src/sbc_lane.sv =====
// ----------------------------------------------------------------------------
// sbc_lane
// One axis: edge arithmetic at twice scale, then entry and exit dividers.
// ----------------------------------------------------------------------------
module sbc_lane #(
	parameter int FB = 16,
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [CW-1:0] apos,
	input  logic [CW-2:0]        asize,
	input  logic signed [CW-1:0] bpos,
	input  logic [CW-2:0]        bsize,
	input  logic signed [CW-1:0] vel,
	output logic signed [FB+2:0] t_entry,
	output logic signed [FB+2:0] t_exit,
	output sbc_pkg::axis_flags_t flags
);
	localparam int DW = CW + 3;
	localparam int NW = CW + 1;
	localparam int LAT = FB + 2;

	logic signed [DW-1:0] amin_c, amax_c, bmin_c, bmax_c;
	logic signed [DW-1:0] den_d_c, dex_d_c;
	logic [NW-1:0]        den_c;
	sbc_pkg::axis_flags_t flg_c;

	logic signed [DW-1:0] den_dist_s1, dex_dist_s1;
	logic [NW-1:0]        den_s1;
	sbc_pkg::axis_flags_t flg_dly [0:LAT];

	// box edges at twice scale and gap distances
	always_comb begin
		amin_c = DW'(apos) * 2 - DW'(asize);
		amax_c = DW'(apos) * 2 + DW'(asize);
		bmin_c = DW'(bpos) * 2 - DW'(bsize);
		bmax_c = DW'(bpos) * 2 + DW'(bsize);
		flg_c.zero_vel = (vel == '0);
		flg_c.overlap  = (amin_c < bmax_c) && (bmin_c < amax_c);
		flg_c.vel_neg  = vel[CW-1];
		den_c = vel[CW-1] ? NW'(-(NW'(vel))) << 1 : NW'(vel) << 1;
		if (vel[CW-1]) begin
			den_d_c = amin_c - bmax_c;
			dex_d_c = amax_c - bmin_c;
		end else begin
			den_d_c = bmin_c - amax_c;
			dex_d_c = bmax_c - amin_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_dist_s1 <= den_d_c;
			dex_dist_s1 <= dex_d_c;
			den_s1      <= flg_c.zero_vel ? NW'(1) : den_c;
		end
	end

	// flags ride alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++)
				flg_dly[i] <= '0;
		end else if (en) begin
			flg_dly[0] <= flg_c;
			for (int i = 1; i <= LAT; i++)
				flg_dly[i] <= flg_dly[i-1];
		end
	end

	assign flags = flg_dly[LAT];

	sbc_div #(.FB(FB), .DW(DW), .NW(NW)) u_div_entry (
		.clk(clk), .arst_n(arst_n), .en(en),
		.gap(den_dist_s1), .den(den_s1), .quo(t_entry)
	);

	sbc_div #(.FB(FB), .DW(DW), .NW(NW)) u_div_exit (
		.clk(clk), .arst_n(arst_n), .en(en),
		.gap(dex_dist_s1), .den(den_s1), .quo(t_exit)
	);
endmodule

// ===== src/swept_box_collision.sv =====
// ----------------------------------------------------------------------------
// swept_box_collision
// Swept axis-aligned box test in 3D with three axis lanes and a merge stage.
// ----------------------------------------------------------------------------
// Takes one box pair request per clock while the pipeline is not held and
// returns one result per request in order. Each axis lane uses restoring
// dividers, which produce one quotient bit per pipeline stage; the whole
// pipeline holds while a finished result is not taken. Mover sizes are to be
// written through the cfg port only while no request is in flight; the block itself does not enforce this.
module swept_box_collision #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [COORD_WIDTH-2:0] cfg_data,
	sbc_req_if.sink                req,
	sbc_rsp_if.source              rsp
);
	localparam int FB = FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int LAT = FB + 3;
	localparam logic signed [FB+2:0] TSAT = (FB+3)'(2) <<< FB;
	localparam logic signed [FB+2:0] ONE_T = (FB+3)'(1) <<< FB;
	localparam logic [CW-2:0] SIZE_RST = (CW-1)'(1) << FB;

	logic [CW-2:0] size_x_q, size_y_q, size_z_q;
	logic          en;
	logic [LAT-1:0] vld_q;

	logic signed [FB+2:0] ten [0:2];
	logic signed [FB+2:0] tex [0:2];
	sbc_pkg::axis_flags_t fl [0:2];

	logic signed [FB+2:0] en_c [0:2];
	logic signed [FB+2:0] ex_c [0:2];
	logic signed [FB+2:0] entry_c, exit_c;
	logic                 hit_c;
	logic [1:0]           pick_c;
	logic                 vneg_c;
	logic signed [1:0]    nsign_c;

	// mover size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RST;
			size_y_q <= SIZE_RST;
			size_z_q <= SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbc_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				sbc_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				sbc_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: move when the output slot is free or being taken
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	sbc_lane #(.FB(FB), .CW(CW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.apos(req.mover_pos_x), .asize(size_x_q),
		.bpos(req.box_pos_x), .bsize(req.box_size_x), .vel(req.vel_x),
		.t_entry(ten[0]), .t_exit(tex[0]), .flags(fl[0])
	);

	sbc_lane #(.FB(FB), .CW(CW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.apos(req.mover_pos_y), .asize(size_y_q),
		.bpos(req.box_pos_y), .bsize(req.box_size_y), .vel(req.vel_y),
		.t_entry(ten[1]), .t_exit(tex[1]), .flags(fl[1])
	);

	sbc_lane #(.FB(FB), .CW(CW)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.apos(req.mover_pos_z), .asize(size_z_q),
		.bpos(req.box_pos_z), .bsize(req.box_size_z), .vel(req.vel_z),
		.t_entry(ten[2]), .t_exit(tex[2]), .flags(fl[2])
	);

	// merge: latest entry, earliest exit, tie-ordered normal
	always_comb begin
		hit_c = 1'b1;
		for (int a = 0; a < 3; a++) begin
			en_c[a] = fl[a].zero_vel ? -TSAT : ten[a];
			ex_c[a] = fl[a].zero_vel ? TSAT : tex[a];
			if (fl[a].zero_vel && !fl[a].overlap)
				hit_c = 1'b0;
		end
		entry_c = en_c[0];
		if (en_c[1] > entry_c) entry_c = en_c[1];
		if (en_c[2] > entry_c) entry_c = en_c[2];
		exit_c = ex_c[0];
		if (ex_c[1] < exit_c) exit_c = ex_c[1];
		if (ex_c[2] < exit_c) exit_c = ex_c[2];
		if (entry_c < 0 || entry_c > ONE_T || entry_c > exit_c)
			hit_c = 1'b0;
		if (en_c[0] > en_c[2])
			pick_c = (en_c[0] > en_c[1]) ? 2'd0 : 2'd1;
		else
			pick_c = (en_c[2] > en_c[1]) ? 2'd2 : 2'd1;
		case (pick_c)
			2'd0:    vneg_c = fl[0].vel_neg;
			2'd2:    vneg_c = fl[2].vel_neg;
			default: vneg_c = fl[1].vel_neg;
		endcase
		nsign_c = vneg_c ? 2'sd1 : -2'sd1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.hit_time <= hit_c ? entry_c[FB:0] : ONE_T[FB:0];
			rsp.normal_x <= (hit_c && pick_c == 2'd0) ? nsign_c : 2'sd0;
			rsp.normal_y <= (hit_c && pick_c == 2'd1) ? nsign_c : 2'sd0;
			rsp.normal_z <= (hit_c && pick_c == 2'd2) ? nsign_c : 2'sd0;
		end
	end

	// checks
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.hit_time <= ONE_T[FB:0])
		else $error("hit time above one");

	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.normal_x != 2'sd0, rsp.normal_y != 2'sd0,
			rsp.normal_z != 2'sd0}))
		else $error("more than one normal component set");

	a_normal_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.normal_x != 2'b10 && rsp.normal_y != 2'b10 &&
			rsp.normal_z != 2'b10))
		else $error("normal component out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_q[0])
		else $error("accepted request lost at pipe entry");
endmodule
